@@ design/pght_pkg.sv @@
// package: constants, payload types, state codes and helpers for the particle grid hash
`timescale 1ns / 1ps
package pght_pkg;

   localparam int GRID_WIDTH    = 64;
   localparam int GRID_HEIGHT   = 64;
   localparam int MAX_PARTICLES = 4096;
   localparam int FACE_REACH    = 2;

   localparam int NUM_CELLS = GRID_WIDTH * GRID_HEIGHT;
   localparam int CELL_W    = $clog2(NUM_CELLS);
   localparam int ADDR_W    = $clog2(MAX_PARTICLES);
   localparam int PTR_W     = $clog2(MAX_PARTICLES + 1);

   localparam int POS_W   = 14;
   localparam int VEL_W   = 16;
   localparam int FLEN_W  = 15;
   localparam int VAL_W   = 16;
   localparam int STORE_W = 2 * POS_W + 2 * VEL_W;

   localparam int TENT_RADIUS = 384;
   localparam int TENT_W      = 9;
   localparam int W_W         = 2 * TENT_W;
   localparam int MUL_A_W     = W_W + 1;
   localparam int MUL_B_W     = VEL_W + 1;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;

   localparam int SUMW_W = W_W + ADDR_W;
   localparam int SUMV_W = W_W + VEL_W + ADDR_W + 1;
   localparam int DIVN_W = SUMV_W + 1;
   localparam int DIVD_W = SUMW_W + 1;
   localparam int DIVC_W = $clog2(DIVN_W + 1);

   localparam int D2_W     = 2 * POS_W + 1;
   localparam int SQ_STEPS = (D2_W + 1) / 2;
   localparam int SQ_W     = D2_W + 1;
   localparam int SQC_W    = $clog2(SQ_STEPS + 1);

   localparam int OFS_W = $clog2(2 * FACE_REACH + 1);
   localparam int CRD_W = 11;

   typedef enum logic [1:0] {
      KIND_CLEAR   = 2'd0,
      KIND_INSERT  = 2'd1,
      KIND_FACE    = 2'd2,
      KIND_NEAREST = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type                   kind;
      logic [POS_W-1:0]           pos_x;
      logic [POS_W-1:0]           pos_y;
      logic signed [VEL_W-1:0]    vel_u;
      logic signed [VEL_W-1:0]    vel_v;
      logic                       component;
      logic [FLEN_W-1:0]          face_length;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic                    found;
      logic                    overflowed;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INS,
      ST_CELL,
      ST_HEAD,
      ST_PART,
      ST_ACC,
      ST_NEXT,
      ST_DIV,
      ST_SQRT,
      ST_DONE
   } state_type;

   function automatic logic [CRD_W-1:0] cell_coord(input logic [POS_W-1:0] pos,
                                                  input int limit);
      logic [CRD_W-1:0] c;
      c = CRD_W'(pos >> 8);
      if (c >= CRD_W'(limit)) begin
         c = CRD_W'(limit - 1);
      end
      return c;
   endfunction

endpackage

@@ design/pght_ram.sv @@
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
module pght_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/particle_grid_hash_transfer.sv @@
// top level: particle grid hash with tent-weight face query and nearest query
// clear item: sweep of every cell of the head ram, no result
// insert item: head read, then head and particle writes, no result
// query: walks each cell of the window and the particle chain of each, then
//   a bit-serial divide (face) or root (nearest), then loads the result
// reset: control cleared, then the same head sweep before the first item
`timescale 1ns / 1ps
module particle_grid_hash_transfer
   import pght_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   state_type                state_ff, state_in;
   req_type                  req_ff, req_in;
   logic [PTR_W-1:0]         count_ff, count_in;
   logic                     ovf_ff, ovf_in;
   logic [CELL_W-1:0]        clr_ff, clr_in;
   logic [CRD_W-1:0]         cx_ff, cx_in, cy_ff, cy_in;
   logic [OFS_W-1:0]         di_ff, di_in, dj_ff, dj_in;
   logic [PTR_W-1:0]         idx_ff, idx_in;
   logic [W_W-1:0]           w_ff, w_in;
   logic [2*POS_W-1:0]       sq_ff, sq_in;
   logic [SUMW_W-1:0]        sumw_ff, sumw_in;
   logic signed [SUMV_W-1:0] sumv_ff, sumv_in;
   logic [D2_W-1:0]          best_ff, best_in;
   logic                     any_ff, any_in;
   logic [DIVD_W-1:0]        rem_ff, rem_in;
   logic [DIVN_W-1:0]        numq_ff, numq_in;
   logic [DIVC_W-1:0]        dcnt_ff, dcnt_in;
   logic [D2_W-1:0]          sqm_ff, sqm_in;
   logic [SQ_W-1:0]          sqr_ff, sqr_in, sqbit_ff, sqbit_in;
   logic [SQC_W-1:0]         scnt_ff, scnt_in;
   logic [VAL_W-1:0]         res_val_ff, res_val_in;
   logic                     res_found_ff, res_found_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic                     head_wr_en, head_rd_en;
   logic [CELL_W-1:0]        head_wr_addr, head_rd_addr;
   logic [PTR_W-1:0]         head_wr_data, head_rd_data;
   logic                     part_wr_en, part_rd_en;
   logic [ADDR_W-1:0]        part_wr_addr, part_rd_addr;
   logic [PTR_W-1:0]         link_rd_data;
   logic [STORE_W-1:0]       store_wr_data, store_rd_data;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod;

   assign prod = mul_a * mul_b;

   pght_ram #(.WIDTH(PTR_W), .DEPTH(NUM_CELLS)) u_head (
      .clock   (clock),
      .wr_en   (head_wr_en),
      .wr_addr (head_wr_addr),
      .wr_data (head_wr_data),
      .rd_en   (head_rd_en),
      .rd_addr (head_rd_addr),
      .rd_data (head_rd_data)
   );

   pght_ram #(.WIDTH(PTR_W), .DEPTH(MAX_PARTICLES)) u_link (
      .clock   (clock),
      .wr_en   (part_wr_en),
      .wr_addr (part_wr_addr),
      .wr_data (head_rd_data),
      .rd_en   (part_rd_en),
      .rd_addr (part_rd_addr),
      .rd_data (link_rd_data)
   );

   pght_ram #(.WIDTH(STORE_W), .DEPTH(MAX_PARTICLES)) u_store (
      .clock   (clock),
      .wr_en   (part_wr_en),
      .wr_addr (part_wr_addr),
      .wr_data (store_wr_data),
      .rd_en   (part_rd_en),
      .rd_addr (part_rd_addr),
      .rd_data (store_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff       <= req_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      di_ff        <= di_in;
      dj_ff        <= dj_in;
      idx_ff       <= idx_in;
      w_ff         <= w_in;
      sq_ff        <= sq_in;
      sumw_ff      <= sumw_in;
      sumv_ff      <= sumv_in;
      best_ff      <= best_in;
      any_ff       <= any_in;
      rem_ff       <= rem_in;
      numq_ff      <= numq_in;
      dcnt_ff      <= dcnt_in;
      sqm_ff       <= sqm_in;
      sqr_ff       <= sqr_in;
      sqbit_ff     <= sqbit_in;
      scnt_ff      <= scnt_in;
      res_val_ff   <= res_val_in;
      res_found_ff <= res_found_in;
      rsp_ff       <= rsp_in;
   end

   always_comb begin
      int                       reach;
      int                       ni;
      int                       nj;
      logic                     in_grid;
      logic [CELL_W-1:0]        nb_cell;
      logic [CRD_W-1:0]         acx;
      logic [CRD_W-1:0]         acy;
      logic                     adv;
      logic [POS_W-1:0]         sx;
      logic [POS_W-1:0]         sy;
      logic signed [VEL_W-1:0]  svel;
      logic [POS_W-1:0]         dx;
      logic [POS_W-1:0]         dy;
      logic [D2_W-1:0]          d2;
      logic [DIVD_W:0]          rem_sh;
      logic [DIVD_W-1:0]        dvs;
      logic [SUMV_W-1:0]        mag;
      logic [SQ_W-1:0]          sq_t;
      logic [SQ_W-1:0]          root;
      logic [OFS_W-1:0]         last;

      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      clr_in       = clr_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      di_in        = di_ff;
      dj_in        = dj_ff;
      idx_in       = idx_ff;
      w_in         = w_ff;
      sq_in        = sq_ff;
      sumw_in      = sumw_ff;
      sumv_in      = sumv_ff;
      best_in      = best_ff;
      any_in       = any_ff;
      rem_in       = rem_ff;
      numq_in      = numq_ff;
      dcnt_in      = dcnt_ff;
      sqm_in       = sqm_ff;
      sqr_in       = sqr_ff;
      sqbit_in     = sqbit_ff;
      scnt_in      = scnt_ff;
      res_val_in   = res_val_ff;
      res_found_in = res_found_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      head_wr_en    = 1'b0;
      head_wr_addr  = clr_ff;
      head_wr_data  = PTR_W'(MAX_PARTICLES);
      head_rd_en    = 1'b0;
      head_rd_addr  = '0;
      part_wr_en    = 1'b0;
      part_wr_addr  = count_ff[ADDR_W-1:0];
      part_rd_en    = 1'b0;
      part_rd_addr  = idx_ff[ADDR_W-1:0];
      store_wr_data = {req_ff.pos_x, req_ff.pos_y, req_ff.vel_u, req_ff.vel_v};
      mul_a         = '0;
      mul_b         = '0;
      adv           = 1'b0;

      reach   = (req_ff.kind == KIND_FACE) ? FACE_REACH : 1;
      last    = OFS_W'(2 * reach);
      ni      = int'(cx_ff) + int'(di_ff) - reach;
      nj      = int'(cy_ff) + int'(dj_ff) - reach;
      in_grid = (ni >= 0) && (ni < GRID_WIDTH) && (nj >= 0) && (nj < GRID_HEIGHT);
      nb_cell = CELL_W'(nj * GRID_WIDTH + ni);

      acx = cell_coord(req_data.pos_x, GRID_WIDTH);
      acy = cell_coord(req_data.pos_y, GRID_HEIGHT);

      sx   = store_rd_data[STORE_W-1 -: POS_W];
      sy   = store_rd_data[STORE_W-POS_W-1 -: POS_W];
      svel = req_ff.component ? store_rd_data[VEL_W-1:0] : store_rd_data[2*VEL_W-1 -: VEL_W];
      dx   = (sx > req_ff.pos_x) ? sx - req_ff.pos_x : req_ff.pos_x - sx;
      dy   = (sy > req_ff.pos_y) ? sy - req_ff.pos_y : req_ff.pos_y - sy;
      d2   = D2_W'(sq_ff) + D2_W'(prod[2*POS_W-1:0]);

      rem_sh = {rem_ff, numq_ff[DIVN_W-1]};
      dvs    = {sumw_ff, 1'b0};
      mag    = sumv_ff[SUMV_W-1] ? SUMV_W'(-sumv_ff) : SUMV_W'(sumv_ff);
      sq_t   = sqr_ff + sqbit_ff;
      root   = ({1'b0, sqm_ff} > sqr_ff) ? sqr_ff + 1'b1 : sqr_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            head_wr_en = 1'b1;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == CELL_W'(NUM_CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               cx_in    = acx;
               cy_in    = acy;
               di_in    = '0;
               dj_in    = '0;
               sumw_in  = '0;
               sumv_in  = '0;
               any_in   = 1'b0;
               case (req_data.kind)
                  KIND_CLEAR: begin
                     count_in = '0;
                     clr_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  KIND_INSERT: begin
                     if (count_ff == PTR_W'(MAX_PARTICLES)) begin
                        ovf_in = 1'b1;
                     end else begin
                        head_rd_en   = 1'b1;
                        head_rd_addr = CELL_W'(int'(acy) * GRID_WIDTH + int'(acx));
                        state_in     = ST_INS;
                     end
                  end
                  KIND_FACE: begin
                     if (req_data.face_length > FLEN_W'(TENT_RADIUS)) begin
                        res_val_in   = '0;
                        res_found_in = 1'b0;
                        state_in     = ST_DONE;
                     end else begin
                        state_in = ST_CELL;
                     end
                  end
                  default: begin
                     state_in = ST_CELL;
                  end
               endcase
            end
         end
         ST_INS: begin
            head_wr_en   = 1'b1;
            head_wr_addr = CELL_W'(int'(cy_ff) * GRID_WIDTH + int'(cx_ff));
            head_wr_data = count_ff;
            part_wr_en   = 1'b1;
            count_in     = count_ff + 1'b1;
            state_in     = ST_IDLE;
         end
         ST_CELL: begin
            if (in_grid) begin
               head_rd_en   = 1'b1;
               head_rd_addr = nb_cell;
               state_in     = ST_HEAD;
            end else begin
               adv = 1'b1;
            end
         end
         ST_HEAD: begin
            idx_in = head_rd_data;
            if (head_rd_data < count_ff) begin
               part_rd_en   = 1'b1;
               part_rd_addr = head_rd_data[ADDR_W-1:0];
               state_in     = ST_PART;
            end else begin
               adv = 1'b1;
            end
         end
         ST_PART: begin
            if (req_ff.kind == KIND_FACE) begin
               if ((dx < POS_W'(TENT_RADIUS)) && (dy < POS_W'(TENT_RADIUS))) begin
                  mul_a    = MUL_A_W'(TENT_RADIUS - int'(dx));
                  mul_b    = MUL_B_W'(TENT_RADIUS - int'(dy));
                  w_in     = prod[W_W-1:0];
                  state_in = ST_ACC;
               end else begin
                  state_in = ST_NEXT;
               end
            end else begin
               mul_a    = MUL_A_W'(dx);
               mul_b    = MUL_B_W'(dx);
               sq_in    = prod[2*POS_W-1:0];
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            if (req_ff.kind == KIND_FACE) begin
               mul_a   = MUL_A_W'(w_ff);
               mul_b   = MUL_B_W'(svel);
               sumw_in = sumw_ff + SUMW_W'(w_ff);
               sumv_in = sumv_ff + SUMV_W'(prod);
            end else begin
               mul_a  = MUL_A_W'(dy);
               mul_b  = MUL_B_W'(dy);
               any_in = 1'b1;
               if (!any_ff || (d2 < best_ff)) begin
                  best_in = d2;
               end
            end
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            idx_in = link_rd_data;
            if (link_rd_data < count_ff) begin
               part_rd_en   = 1'b1;
               part_rd_addr = link_rd_data[ADDR_W-1:0];
               state_in     = ST_PART;
            end else begin
               adv = 1'b1;
            end
         end
         ST_DIV: begin
            if (dcnt_ff == DIVC_W'(DIVN_W)) begin
               res_found_in = 1'b1;
               if (sumv_ff[SUMV_W-1]) begin
                  res_val_in = (numq_ff > DIVN_W'(32768)) ? VAL_W'(16'h8000)
                                                          : VAL_W'(-numq_ff[VAL_W-1:0]);
               end else begin
                  res_val_in = (numq_ff > DIVN_W'(32767)) ? VAL_W'(16'h7fff)
                                                          : numq_ff[VAL_W-1:0];
               end
               state_in = ST_DONE;
            end else begin
               if (rem_sh >= {1'b0, dvs}) begin
                  rem_in  = DIVD_W'(rem_sh - {1'b0, dvs});
                  numq_in = {numq_ff[DIVN_W-2:0], 1'b1};
               end else begin
                  rem_in  = rem_sh[DIVD_W-1:0];
                  numq_in = {numq_ff[DIVN_W-2:0], 1'b0};
               end
               dcnt_in = dcnt_ff + 1'b1;
            end
         end
         ST_SQRT: begin
            if (scnt_ff == SQC_W'(SQ_STEPS)) begin
               res_found_in = 1'b1;
               res_val_in   = (root > SQ_W'(32767)) ? VAL_W'(16'h7fff) : root[VAL_W-1:0];
               state_in     = ST_DONE;
            end else begin
               if ({1'b0, sqm_ff} >= sq_t) begin
                  sqm_in = D2_W'({1'b0, sqm_ff} - sq_t);
                  sqr_in = (sqr_ff >> 1) + sqbit_ff;
               end else begin
                  sqr_in = sqr_ff >> 1;
               end
               sqbit_in = sqbit_ff >> 2;
               scnt_in  = scnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_in.value      = res_val_ff;
               rsp_in.found      = res_found_ff;
               rsp_in.overflowed = ovf_ff;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // step to the next cell of the window, or wrap up the query
      if (adv) begin
         state_in = ST_CELL;
         if (di_ff == last) begin
            di_in = '0;
            if (dj_ff == last) begin
               if (req_ff.kind == KIND_FACE) begin
                  if (sumw_ff == '0) begin
                     res_val_in   = '0;
                     res_found_in = 1'b0;
                     state_in     = ST_DONE;
                  end else begin
                     numq_in  = DIVN_W'({mag, 1'b0}) + DIVN_W'(sumw_ff);
                     rem_in   = '0;
                     dcnt_in  = '0;
                     state_in = ST_DIV;
                  end
               end else begin
                  if (!any_ff) begin
                     res_val_in   = '0;
                     res_found_in = 1'b0;
                     state_in     = ST_DONE;
                  end else begin
                     sqm_in   = best_ff;
                     sqr_in   = '0;
                     sqbit_in = SQ_W'(1) << (2 * (SQ_STEPS - 1));
                     scnt_in  = '0;
                     state_in = ST_SQRT;
                  end
               end
            end else begin
               dj_in = dj_ff + 1'b1;
            end
         end else begin
            di_in = di_ff + 1'b1;
         end
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= PTR_W'(MAX_PARTICLES))
      else $error("particle count beyond capacity");

   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(ovf_ff))
      else $error("overflow flag dropped");

   a_no_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.found) |-> (rsp_ff.value == '0))
      else $error("value set without a find");

   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |=> ((state_ff == ST_CLEAR) || (clr_ff == '0)))
      else $error("head sweep left early");

endmodule

@@ dv/testbench.sv @@
// testbench: directed table and random insert/query sequences checked against a predictor
`timescale 1ns / 1ps
module testbench;
   import pght_pkg::*;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type rsp;
   } row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   particle_grid_hash_transfer dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // predictor state
   int unsigned    head_of[NUM_CELLS];
   int unsigned    link_of[MAX_PARTICLES];
   int unsigned    part_x[MAX_PARTICLES];
   int unsigned    part_y[MAX_PARTICLES];
   int             part_u[MAX_PARTICLES];
   int             part_v[MAX_PARTICLES];
   int unsigned    part_count;
   bit             dropped_flag;

   rsp_type        pending_rsp[$];
   row_type        table_rows[$];
   int             errors;
   int             mismatches;
   int             burst_left;
   bit             hold_req;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("testbench: done, errors");
      $finish;
   end

   function automatic int grid_cell(int unsigned p, int limit);
      int c;
      c = p >> 8;
      return (c >= limit) ? limit - 1 : c;
   endfunction

   function automatic int unsigned abs_diff(int unsigned a, int unsigned b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic longint unsigned root_rounded(longint unsigned n);
      longint unsigned r, bitv, m;
      r = 0;
      bitv = 64'd1 << 62;
      m = n;
      while (bitv > m) bitv >>= 2;
      while (bitv != 0) begin
         if (m >= r + bitv) begin
            m -= r + bitv;
            r = (r >> 1) + bitv;
         end else begin
            r >>= 1;
         end
         bitv >>= 2;
      end
      if (n - r * r > r) r++;
      return r;
   endfunction

   function automatic void clear_grid();
      for (int i = 0; i < NUM_CELLS; i++) head_of[i] = MAX_PARTICLES;
      part_count = 0;
   endfunction

   function automatic rsp_type face_average(int unsigned fx, int unsigned fy, bit comp);
      rsp_type         r;
      int              cx, cy, ni, nj;
      int unsigned     idx, dx, dy;
      longint unsigned sum_w, w, mag, q;
      longint          sum_v;
      cx = grid_cell(fx, GRID_WIDTH);
      cy = grid_cell(fy, GRID_HEIGHT);
      sum_w = 0;
      sum_v = 0;
      r = '0;
      for (int dj = -FACE_REACH; dj <= FACE_REACH; dj++) begin
         for (int di = -FACE_REACH; di <= FACE_REACH; di++) begin
            ni = cx + di;
            nj = cy + dj;
            if (ni >= 0 && ni < GRID_WIDTH && nj >= 0 && nj < GRID_HEIGHT) begin
               idx = head_of[nj * GRID_WIDTH + ni];
               while (idx < part_count) begin
                  dx = abs_diff(part_x[idx], fx);
                  dy = abs_diff(part_y[idx], fy);
                  if (dx < TENT_RADIUS && dy < TENT_RADIUS) begin
                     w = longint'(TENT_RADIUS - dx) * longint'(TENT_RADIUS - dy);
                     sum_w += w;
                     sum_v += longint'(w) * longint'(comp ? part_v[idx] : part_u[idx]);
                  end
                  idx = link_of[idx];
               end
            end
         end
      end
      if (sum_w != 0) begin
         mag = (sum_v < 0) ? longint'(-sum_v) : longint'(sum_v);
         q = (2 * mag + sum_w) / (2 * sum_w);
         if (sum_v < 0) r.value = (q > 32768) ? 16'sh8000 : VAL_W'(-longint'(q));
         else r.value = (q > 32767) ? 16'sd32767 : VAL_W'(q);
         r.found = 1'b1;
      end
      return r;
   endfunction

   function automatic rsp_type nearest_distance(int unsigned x, int unsigned y);
      rsp_type         r;
      int              cx, cy, ni, nj;
      int unsigned     idx;
      longint unsigned best, d2, dx, dy, s;
      bit              any;
      cx = grid_cell(x, GRID_WIDTH);
      cy = grid_cell(y, GRID_HEIGHT);
      best = 0;
      any = 0;
      r = '0;
      for (int dj = -1; dj <= 1; dj++) begin
         for (int di = -1; di <= 1; di++) begin
            ni = cx + di;
            nj = cy + dj;
            if (ni >= 0 && ni < GRID_WIDTH && nj >= 0 && nj < GRID_HEIGHT) begin
               idx = head_of[nj * GRID_WIDTH + ni];
               while (idx < part_count) begin
                  dx = abs_diff(part_x[idx], x);
                  dy = abs_diff(part_y[idx], y);
                  d2 = dx * dx + dy * dy;
                  if (!any || d2 < best) best = d2;
                  any = 1;
                  idx = link_of[idx];
               end
            end
         end
      end
      if (any) begin
         s = root_rounded(best);
         r.value = (s > 32767) ? 16'sd32767 : VAL_W'(s);
         r.found = 1'b1;
      end
      return r;
   endfunction

   // advances the grid state by one item, returns whether a result follows
   function automatic bit hash_apply(req_type q, output rsp_type r);
      int unsigned cell_idx;
      r = '0;
      case (q.kind)
         KIND_CLEAR: begin
            clear_grid();
            return 0;
         end
         KIND_INSERT: begin
            if (part_count >= MAX_PARTICLES) begin
               dropped_flag = 1;
            end else begin
               cell_idx = grid_cell(q.pos_y, GRID_HEIGHT) * GRID_WIDTH
                          + grid_cell(q.pos_x, GRID_WIDTH);
               part_x[part_count] = q.pos_x;
               part_y[part_count] = q.pos_y;
               part_u[part_count] = q.vel_u;
               part_v[part_count] = q.vel_v;
               link_of[part_count] = head_of[cell_idx];
               head_of[cell_idx] = part_count;
               part_count++;
            end
            return 0;
         end
         KIND_FACE: begin
            if (q.face_length <= TENT_RADIUS) r = face_average(q.pos_x, q.pos_y, q.component);
         end
         default: begin
            r = nearest_distance(q.pos_x, q.pos_y);
         end
      endcase
      r.overflowed = dropped_flag;
      return 1;
   endfunction

   function automatic req_type make_req(kind_type k, int unsigned x, int unsigned y,
                                        int u, int v, bit c, int unsigned fl);
      req_type q;
      q.kind = k;
      q.pos_x = POS_W'(x);
      q.pos_y = POS_W'(y);
      q.vel_u = VEL_W'(u);
      q.vel_v = VEL_W'(v);
      q.component = c;
      q.face_length = FLEN_W'(fl);
      return q;
   endfunction

   task automatic add_row(kind_type k, int unsigned x, int unsigned y, int u, int v,
                          bit c, int unsigned fl, bit typed, int val, bit fnd);
      row_type t;
      t.req = make_req(k, x, y, u, v, c, fl);
      t.typed = typed;
      t.rsp.value = VAL_W'(val);
      t.rsp.found = fnd;
      t.rsp.overflowed = 1'b0;
      table_rows.insert(table_rows.size(), t);
   endtask

   task automatic send(req_type q, bit typed, rsp_type e);
      rsp_type p;
      req_data <= q;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      if (hash_apply(q, p)) pending_rsp.insert(pending_rsp.size(), typed ? e : p);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         burst_left = $urandom_range(0, 20);
      end else begin
         burst_left--;
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   function automatic int unsigned near_pos(int unsigned base, int spread);
      int p;
      p = int'(base) + $urandom_range(0, 2 * spread) - spread;
      if (p < 0) p = 0;
      if (p > 16383) p = 16383;
      return p;
   endfunction

   function automatic req_type noise_req();
      return make_req(kind_type'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                      $urandom, 1'($urandom), $urandom);
   endfunction

   // results
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            errors++;
            if (mismatches < 10) $display("unexpected item: %p", rsp_data);
            mismatches++;
         end else begin
            if (rsp_data !== pending_rsp[0]) begin
               errors++;
               if (mismatches < 10)
                  $display("mismatch: expected value %0d found %0b ovf %0b, got %0d %0b %0b",
                           pending_rsp[0].value, pending_rsp[0].found,
                           pending_rsp[0].overflowed, rsp_data.value, rsp_data.found,
                           rsp_data.overflowed);
               mismatches++;
            end
            void'(pending_rsp.pop_front());
         end
      end
   end

   // receiver stall pattern
   initial begin
      int mode;
      int len;
      rsp_ready = 1'b0;
      hold_req = 0;
      @(negedge reset);
      forever begin
         if (hold_req) begin
            hold_req = 0;
            repeat (3000) begin
               @(posedge clock);
               rsp_ready <= 1'b0;
            end
         end
         mode = $urandom_range(0, 3);
         len = $urandom_range(1, 200);
         repeat (len) begin
            @(posedge clock);
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= ($urandom_range(0, 7) == 0);
               default: rsp_ready <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // stimulus
   initial begin
      int          sent;
      bit          filled;
      int unsigned bx, by;
      rsp_type     none;
      req_type     q;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      errors = 0;
      mismatches = 0;
      burst_left = 0;
      none = '0;
      clear_grid();
      dropped_flag = 0;

      add_row(KIND_NEAREST, 100, 100, 0, 0, 0, 0, 1, 0, 0);
      add_row(KIND_FACE, 100, 100, 0, 0, 0, 0, 1, 0, 0);
      add_row(KIND_INSERT, 0, 0, 32767, -32768, 0, 0, 0, 0, 0);
      add_row(KIND_NEAREST, 0, 0, 0, 0, 0, 0, 1, 0, 1);
      add_row(KIND_FACE, 0, 0, 0, 0, 0, 384, 1, 32767, 1);
      add_row(KIND_FACE, 0, 0, 0, 0, 1, 384, 1, -32768, 1);
      add_row(KIND_FACE, 0, 0, 0, 0, 0, 385, 1, 0, 0);
      add_row(KIND_FACE, 0, 0, 0, 0, 1, 32767, 1, 0, 0);
      add_row(KIND_INSERT, 16383, 16383, -32768, 32767, 1, 32767, 0, 0, 0);
      add_row(KIND_NEAREST, 16383, 16383, 0, 0, 0, 0, 1, 0, 1);
      add_row(KIND_NEAREST, 8192, 8192, 0, 0, 0, 0, 1, 0, 0);
      add_row(KIND_FACE, 16383, 16383, 0, 0, 0, 0, 1, -32768, 1);
      add_row(KIND_INSERT, 300, 100, 100, -100, 0, 0, 0, 0, 0);
      add_row(KIND_FACE, 200, 100, 0, 0, 0, 100, 0, 0, 0);
      add_row(KIND_FACE, 200, 100, 0, 0, 1, 100, 0, 0, 0);
      add_row(KIND_NEAREST, 500, 300, 0, 0, 0, 0, 0, 0, 0);
      add_row(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(KIND_INSERT, 1000, 1000, 5, 7, 0, 0, 0, 0, 0);
      // particle exactly one tent radius away carries no weight
      add_row(KIND_FACE, 1384, 1000, 0, 0, 0, 0, 1, 0, 0);
      add_row(KIND_FACE, 1383, 1000, 0, 0, 0, 0, 1, 5, 1);
      add_row(KIND_FACE, 1000, 616, 0, 0, 1, 0, 1, 0, 0);
      add_row(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(KIND_NEAREST, 0, 0, 0, 0, 0, 0, 1, 0, 0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (table_rows[i]) send(table_rows[i].req, table_rows[i].typed, table_rows[i].rsp);
      drain();
      hold_req = 1;

      sent = 0;
      filled = 0;
      while (sent < 2000) begin
         if (!filled && sent >= 900) begin
            // fill past capacity, then query the crowded grid
            filled = 1;
            drain();
            for (int i = 0; i <= MAX_PARTICLES; i++) begin
               send(make_req(KIND_INSERT, $urandom, $urandom, $urandom, $urandom, 0, 0),
                    0, none);
            end
            repeat (6) begin
               send(make_req(kind_type'($urandom_range(2, 3)), $urandom, $urandom, 0, 0,
                             1'($urandom), $urandom_range(0, 384)), 0, none);
            end
            send(make_req(KIND_CLEAR, 0, 0, 0, 0, 0, 0), 0, none);
            sent += MAX_PARTICLES + 8;
         end
         if ($urandom_range(0, 9) == 0) begin
            send(noise_req(), 0, none);
            sent++;
         end else begin
            case ($urandom_range(0, 3))
               0: bx = 0;
               1: bx = 16383;
               default: bx = $urandom_range(0, 16383);
            endcase
            by = ($urandom_range(0, 3) == 0) ? 16383 - $urandom_range(0, 600)
                                             : $urandom_range(0, 16383);
            send(make_req(KIND_CLEAR, 0, 0, 0, 0, 0, 0), 0, none);
            sent++;
            repeat ($urandom_range(0, 12)) begin
               send(make_req(KIND_INSERT, near_pos(bx, 900), near_pos(by, 900),
                             $urandom, $urandom, 1'($urandom), $urandom), 0, none);
               sent++;
            end
            repeat ($urandom_range(1, 8)) begin
               q = make_req(kind_type'($urandom_range(2, 3)), near_pos(bx, 700),
                            near_pos(by, 700), $urandom, $urandom, 1'($urandom),
                            ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 384));
               send(q, 0, none);
               sent++;
            end
         end
         if ($urandom_range(0, 49) == 0) drain();
      end
      send(make_req(KIND_NEAREST, $urandom, $urandom, 0, 0, 0, 0), 0, none);

      drain();
      repeat (5000) @(posedge clock);
      if (errors == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
